// File: design/jet_pkg.sv
// Package for the Julia escape-time engine: widths, register codes, shared
// types and the Q4.28 to wide fixed-point conversion.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jet_pkg;

  // Fixed-point format used inside the iteration loop
  localparam int FRAC_BITS   = 28;
  localparam int COUNT_WIDTH = 16;

  // Port field widths
  localparam int IN_W    = 32;
  localparam int CNT_W   = 16;
  localparam int SFRAC_W = 16;
  localparam int QUO_W   = SFRAC_W + 1;

  // Iterate width: sign, 10 integer bits (|z| stays near 1008), fraction
  localparam int VW = FRAC_BITS + 11;
  // Product width: squares stay below 2^20, sign on top
  localparam int PW = FRAC_BITS + 21;

  // Multiplier split: magnitudes cut into two halves
  localparam int MAG_HALF = (VW + 1) / 2;
  localparam int ACC_W    = 4 * MAG_HALF;

  // Escape threshold on the squared norm
  localparam int ESCAPE_NORM = 1000;
  localparam logic [PW:0] ESC_THR = (PW + 1)'(ESCAPE_NORM) << FRAC_BITS;

  // Input format conversion shifts
  localparam int SHL = (FRAC_BITS >= 28) ? (FRAC_BITS - 28) : 0;
  localparam int SHR = (FRAC_BITS < 28) ? (28 - FRAC_BITS) : 0;

  // Configuration port
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_C_REAL   = 2'd0;
  localparam logic [1:0] REG_C_IMAG   = 2'd1;
  localparam logic [1:0] REG_MAX_ITER = 2'd2;
  localparam logic [15:0] MAX_ITER_RESET = 16'd256;

  typedef struct packed {
    logic signed [IN_W-1:0] c_real;
    logic signed [IN_W-1:0] c_imag;
    logic [15:0]            max_iter;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [PW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic                   start;
    logic [COUNT_WIDTH-1:0] num;
    logic [COUNT_WIDTH-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // Q4.28 -> VW bits with FRAC_BITS fraction bits (floor when narrowing)
  function automatic logic signed [VW-1:0] to_wide(input logic signed [IN_W-1:0] v);
    logic signed [IN_W+SHL-1:0] t;
    t = (IN_W + SHL)'(v);
    t = t <<< SHL;
    t = t >>> SHR;
    return VW'(t);
  endfunction

endpackage

`default_nettype wire

// File: design/jet_pt_if.sv
// Input channel interface: one starting point z per beat.
// Depends on jet_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface jet_pt_if import jet_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] z_real;
  logic signed [IN_W-1:0] z_imag;

  modport source (output valid, z_real, z_imag, input ready);
  modport sink   (input valid, z_real, z_imag, output ready);
endinterface

`default_nettype wire

// File: design/jet_res_if.sv
// Result channel interface: escape count, bounded flag and smooth fraction.
// Depends on jet_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface jet_res_if import jet_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   iteration_count;
  logic               bounded;
  logic [QUO_W-1:0]   smooth_fraction;

  modport source (output valid, iteration_count, bounded, smooth_fraction, input ready);
  modport sink   (input valid, iteration_count, bounded, smooth_fraction, output ready);
endinterface

`default_nettype wire

// File: design/jet_cfg.sv
// APB-style register file: c_real, c_imag and max_iterations.
// Depends on jet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jet_cfg import jet_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready,
  output      cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic [1:0] idx;
  logic       wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.c_real   <= '0;
      cfg_q.c_imag   <= '0;
      cfg_q.max_iter <= MAX_ITER_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_C_REAL:   cfg_q.c_real   <= pwdata;
        REG_C_IMAG:   cfg_q.c_imag   <= pwdata;
        REG_MAX_ITER: cfg_q.max_iter <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_C_REAL:   prdata = cfg_q.c_real;
      REG_C_IMAG:   prdata = cfg_q.c_imag;
      REG_MAX_ITER: prdata = 32'(cfg_q.max_iter);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/jet_mul.sv
// Shared fixed-point multiplier: sign-magnitude product built from four
// half-width partial products, truncated toward zero to FRAC_BITS.
// Depends on jet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jet_mul import jet_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mul_req_t req_i,
  output      mul_rsp_t rsp_o
);

  localparam int H = MAG_HALF;

  logic             busy_q;
  logic [2:0]       step_q;
  logic             done_q;
  logic [2*H-1:0]   ua_q, ub_q;
  logic             neg_q;
  logic [2*H-1:0]   pp_q;
  logic [1:0]       w_q;
  logic [ACC_W-1:0] acc_q;

  logic [VW-1:0]    ua, ub;
  logic [H-1:0]     a_part, b_part;
  logic [ACC_W-1:0] pp_sh;
  logic [ACC_W-1:0] mag_full;
  logic [PW-1:0]    mag;

  // operand magnitudes
  assign ua = req_i.a[VW-1] ? VW'(-req_i.a) : VW'(req_i.a);
  assign ub = req_i.b[VW-1] ? VW'(-req_i.b) : VW'(req_i.b);

  // partial product select: step bit 1 picks high half of a, bit 0 of b
  assign a_part = step_q[1] ? ua_q[2*H-1:H] : ua_q[H-1:0];
  assign b_part = step_q[0] ? ub_q[2*H-1:H] : ub_q[H-1:0];

  // weight of the previous partial product
  always_comb begin
    unique case (w_q)
      2'd0:    pp_sh = ACC_W'(pp_q);
      2'd1:    pp_sh = ACC_W'(pp_q) << H;
      2'd2:    pp_sh = ACC_W'(pp_q) << (2 * H);
      default: pp_sh = '0;
    endcase
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: registers each partial product, accumulates it the next cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ua_q  <= (2 * H)'(ua);
      ub_q  <= (2 * H)'(ub);
      neg_q <= req_i.a[VW-1] ^ req_i.b[VW-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        pp_q <= a_part * b_part;
        w_q  <= 2'(step_q[1]) + 2'(step_q[0]);
      end
      if (step_q != 3'd0) begin
        acc_q <= acc_q + pp_sh;
      end
    end
  end

  // truncate toward zero, then restore sign
  assign mag_full   = acc_q >> FRAC_BITS;
  assign mag        = mag_full[PW-1:0];
  assign rsp_o.done = done_q;
  assign rsp_o.p    = neg_q ? -$signed(mag) : $signed(mag);

endmodule

`default_nettype wire

// File: design/jet_div.sv
// Restoring divider for the smooth fraction: floor(num * 2^16 / den),
// one quotient bit per cycle, valid for num <= den.
// Depends on jet_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jet_div import jet_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output      div_rsp_t rsp_o
);

  localparam int RW = COUNT_WIDTH + 1;

  logic                   busy_q;
  logic [4:0]             step_q;
  logic                   done_q;
  logic [RW-1:0]          rem_q;
  logic [COUNT_WIDTH-1:0] den_q;
  logic [QUO_W-1:0]       quo_q;

  logic [RW-1:0] cand;
  logic          ge;

  // first step takes num as is, later steps shift the remainder
  assign cand = (step_q == 5'd0) ? rem_q : {rem_q[RW-2:0], 1'b0};
  assign ge   = cand >= RW'(den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 5'd1;
        if (step_q == 5'(SFRAC_W)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= RW'(req_i.num);
      den_q <= req_i.den;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (cand - RW'(den_q)) : cand;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

// File: design/julia_escape_time.sv
// Julia escape-time engine. Each input beat carries a starting point z
// (Q4.28); the block iterates z = z*z + c until the squared norm exceeds
// 1000 or max_iterations steps have run, then returns one result beat with
// the escape index, the bounded flag and count/limit as Q1.16. All products
// go through one shared multiplier that builds each product from four
// partial products; an iteration needs three products plus an update
// state (S_STEP). A zero limit skips the iterations; otherwise the 17-step
// bit-serial divider computes the fraction once the loop ends. Input
// ready is high only while the engine is idle; c and the limit come from
// the APB registers.
// Depends on jet_pkg, jet_pt_if, jet_res_if, jet_cfg, jet_mul, jet_div.
`timescale 1ns / 1ps
`default_nettype none

module julia_escape_time import jet_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  jet_pt_if.sink                 pt_i,
  jet_res_if.source              res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MWAIT  = 3'd2;
  localparam logic [2:0] S_STEP   = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  // product select
  localparam logic [1:0] PROD_XX = 2'd0;
  localparam logic [1:0] PROD_YY = 2'd1;
  localparam logic [1:0] PROD_XY = 2'd2;

  cfg_t     cfg;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [2:0]             state_q, state_d;
  logic [1:0]             sel_q, sel_d;
  logic                   first_q, first_d;
  logic [COUNT_WIDTH-1:0] iter_q, iter_d;

  logic signed [VW-1:0]   x_q, x_d, y_q, y_d;
  logic signed [PW-1:0]   sxx_q, sxx_d, syy_q, syy_d, sxy_q, sxy_d;
  logic [COUNT_WIDTH-1:0] lim_q, lim_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   bnd_q, bnd_d;
  logic [QUO_W-1:0]       frac_q, frac_d;

  logic signed [VW-1:0]   cr_w, ci_w;
  logic signed [PW:0]     nr_full, ni_full;
  logic [PW:0]            norm;
  logic [COUNT_WIDTH:0]   iter_p1;
  logic [COUNT_WIDTH-1:0] lim_in;

  jet_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  jet_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  jet_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cr_w   = to_wide(cfg.c_real);
  assign ci_w   = to_wide(cfg.c_imag);
  assign lim_in = COUNT_WIDTH'(cfg.max_iter);

  // next z from the current products
  assign nr_full = (PW + 1)'(sxx_q) - (PW + 1)'(syy_q) + (PW + 1)'(cr_w);
  assign ni_full = ((PW + 1)'(sxy_q) <<< 1) + (PW + 1)'(ci_w);

  // squared norm of the new z (both squares are non-negative)
  assign norm    = (PW + 1)'($unsigned(sxx_q)) + (PW + 1)'($unsigned(syy_q));
  assign iter_p1 = (COUNT_WIDTH + 1)'(iter_q) + (COUNT_WIDTH + 1)'(1);

  // multiplier operands
  always_comb begin
    mul_req.start = (state_q == S_MSTART);
    unique case (sel_q)
      PROD_XX: begin
        mul_req.a = x_q;
        mul_req.b = x_q;
      end
      PROD_YY: begin
        mul_req.a = y_q;
        mul_req.b = y_q;
      end
      default: begin
        mul_req.a = x_q;
        mul_req.b = y_q;
      end
    endcase
  end

  assign div_req.start = (state_q == S_DSTART);
  assign div_req.num   = cnt_q;
  assign div_req.den   = lim_q;

  // handshake and result beat
  assign pt_i.ready            = (state_q == S_IDLE);
  assign res_o.valid           = (state_q == S_OUT);
  assign res_o.iteration_count = CNT_W'(cnt_q);
  assign res_o.bounded         = bnd_q;
  assign res_o.smooth_fraction = frac_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    first_d = first_q;
    iter_d  = iter_q;
    x_d     = x_q;
    y_d     = y_q;
    sxx_d   = sxx_q;
    syy_d   = syy_q;
    sxy_d   = sxy_q;
    lim_d   = lim_q;
    cnt_d   = cnt_q;
    bnd_d   = bnd_q;
    frac_d  = frac_q;

    unique case (state_q)
      S_IDLE: begin
        if (pt_i.valid) begin
          x_d     = to_wide(pt_i.z_real);
          y_d     = to_wide(pt_i.z_imag);
          lim_d   = lim_in;
          iter_d  = '0;
          sel_d   = PROD_XX;
          first_d = 1'b1;
          if (lim_in == '0) begin
            // zero limit: nothing runs, report as bounded
            cnt_d   = '0;
            bnd_d   = 1'b1;
            frac_d  = QUO_W'(1) << SFRAC_W;
            state_d = S_OUT;
          end else begin
            state_d = S_MSTART;
          end
        end
      end
      S_MSTART: state_d = S_MWAIT;
      S_MWAIT: begin
        if (mul_rsp.done) begin
          unique case (sel_q)
            PROD_XX: begin
              sxx_d   = mul_rsp.p;
              sel_d   = PROD_YY;
              state_d = S_MSTART;
            end
            PROD_YY: begin
              syy_d   = mul_rsp.p;
              sel_d   = PROD_XY;
              state_d = S_MSTART;
            end
            default: begin
              sxy_d = mul_rsp.p;
              if (first_q) begin
                first_d = 1'b0;
                state_d = S_STEP;
              end else if (norm > ESC_THR) begin
                cnt_d   = iter_q;
                bnd_d   = 1'b0;
                state_d = S_DSTART;
              end else if (iter_p1 == (COUNT_WIDTH + 1)'(lim_q)) begin
                cnt_d   = lim_q;
                bnd_d   = 1'b1;
                state_d = S_DSTART;
              end else begin
                iter_d  = iter_p1[COUNT_WIDTH-1:0];
                state_d = S_STEP;
              end
            end
          endcase
        end
      end
      S_STEP: begin
        x_d     = VW'(nr_full);
        y_d     = VW'(ni_full);
        sel_d   = PROD_XX;
        state_d = S_MSTART;
      end
      S_DSTART: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_rsp.done) begin
          frac_d  = div_rsp.quo;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (res_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= PROD_XX;
      first_q <= 1'b0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      first_q <= first_d;
      iter_q  <= iter_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    sxx_q  <= sxx_d;
    syy_q  <= syy_d;
    sxy_q  <= sxy_d;
    lim_q  <= lim_d;
    cnt_q  <= cnt_d;
    bnd_q  <= bnd_d;
    frac_q <= frac_d;
  end

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for julia_escape_time: drives starting points, programs c and
// the iteration limit over APB and checks each result beat against an in-bench predictor.
// Depends on jet_pkg, jet_pt_if, jet_res_if and the julia_escape_time RTL.
`timescale 1ns / 1ps

module testbench;
  import jet_pkg::*;

  // Cycle budget: short limits keep bounded points cheap and the 65535-limit
  // points all escape early; the budget leaves a wide margin
  localparam int LIMIT_CYCLES = 5_000_000;
  // Long result-side hold-off, started once this many beats have been taken
  localparam int HOLD_AT  = 150;
  localparam int HOLD_LEN = 400;
  localparam int END_WAIT = 60;

  // Q4.28 reference points
  localparam logic signed [IN_W-1:0] Q_ONE  = 32'sh1000_0000;
  localparam logic signed [IN_W-1:0] Q_TWO  = 32'sh2000_0000;
  localparam logic signed [IN_W-1:0] Q_HALF = 32'sh0800_0000;
  localparam logic signed [IN_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [IN_W-1:0] Q_MIN  = 32'sh8000_0000;

  typedef enum {PT_NEAR, PT_WIDE, PT_FAR, PT_CORNER} pt_kind_e;

  typedef struct {
    logic signed [IN_W-1:0] re;
    logic signed [IN_W-1:0] im;
  } point_t;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic             bounded;
    logic [QUO_W-1:0] frac;
  } escape_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  // APB side
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  jet_pt_if  pt ();
  jet_res_if res ();

  julia_escape_time DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pt_i    (pt),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the register file
  logic signed [IN_W-1:0] cfg_c_real = '0;
  logic signed [IN_W-1:0] cfg_c_imag = '0;
  logic [15:0]            cfg_limit  = MAX_ITER_RESET;

  point_t  points_q[$];
  escape_t escapes_due[$];

  int  errors       = 0;
  int  points_sent  = 0;
  int  n_bounded    = 0;
  int  results_seen = 0;
  int  n_settings   = 1;
  int  cycles       = 0;
  int  tx_gap       = 0;
  int  rx_wait      = 0;
  bit  quiet        = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Q4.28 -> FRAC_BITS fraction bits, floor when narrowing
  function automatic logic signed [127:0] widen(input logic signed [IN_W-1:0] q);
    logic signed [127:0] v;
    v = q;
    if (FRAC_BITS >= 28) v = v <<< (FRAC_BITS - 28);
    else v = v >>> (28 - FRAC_BITS);
    return v;
  endfunction

  // Exact product, truncated toward zero
  function automatic logic signed [127:0] qmul(input logic signed [127:0] a,
                                               input logic signed [127:0] b);
    logic signed [127:0] p;
    p = a * b;
    if (p < 0) return -((-p) >>> FRAC_BITS);
    return p >>> FRAC_BITS;
  endfunction

  // Escape-time iteration for one starting point under the current registers
  function automatic escape_t julia_escape(input logic signed [IN_W-1:0] zr,
                                           input logic signed [IN_W-1:0] zi);
    logic signed [127:0] x, y, nx, ny, cr, ci, thresh;
    int unsigned         limit, step;
    logic                gone;
    escape_t             e;
    limit  = 32'(cfg_limit) & ((32'd1 << COUNT_WIDTH) - 32'd1);
    x      = widen(zr);
    y      = widen(zi);
    cr     = widen(cfg_c_real);
    ci     = widen(cfg_c_imag);
    thresh = 128'sd1000 <<< FRAC_BITS;
    step   = 0;
    gone   = 1'b0;
    while (!gone && step < limit) begin
      nx = qmul(x, x) - qmul(y, y) + cr;
      ny = (qmul(x, y) <<< 1) + ci;
      x  = nx;
      y  = ny;
      if (qmul(x, x) + qmul(y, y) > thresh) gone = 1'b1;
      else step++;
    end
    e.count   = CNT_W'(step);
    e.bounded = !gone;
    e.frac    = (limit == 0) ? QUO_W'(65536) : QUO_W'((64'(step) << 16) / limit);
    return e;
  endfunction

  function automatic void add_point(input logic signed [IN_W-1:0] re,
                                    input logic signed [IN_W-1:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    points_q.push_back(p);
  endfunction

  // Uniform in [-2, 2]
  function automatic logic signed [IN_W-1:0] near_coord();
    return $signed($urandom_range(0, 32'h4000_0000)) - Q_TWO;
  endfunction

  function automatic point_t rand_point(input pt_kind_e kind);
    point_t p;
    logic signed [IN_W-1:0] mag;
    case (kind)
      PT_NEAR: begin
        p.re = near_coord();
        p.im = near_coord();
      end
      PT_WIDE: begin
        p.re = $signed($urandom());
        p.im = $signed($urandom());
      end
      PT_FAR: begin
        // |re| >= 6, |im| <= 0.5: escapes on the first step for |c| <= 2
        mag  = 32'sh6000_0000 + $signed($urandom_range(0, 32'h1FFF_FFFF));
        p.re = $urandom_range(0, 1) ? -mag : mag;
        p.im = $signed($urandom_range(0, 32'h1000_0000)) - Q_HALF;
      end
      default: begin
        case ($urandom_range(0, 5))
          0: p.re = '0;
          1: p.re = Q_ONE;
          2: p.re = -Q_ONE;
          3: p.re = Q_MAX;
          4: p.re = Q_MIN;
          default: p.re = -Q_TWO;
        endcase
        p.im = $urandom_range(0, 1) ? near_coord() : '0;
      end
    endcase
    return p;
  endfunction

  function automatic pt_kind_e mix_kind();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return PT_NEAR;
      6, 7: return PT_WIDE;
      8: return PT_FAR;
      default: return PT_CORNER;
    endcase
  endfunction

  // Short limits for the bulk so bounded points stay cheap
  function automatic logic [15:0] phase_limit(input int p);
    case (p)
      0: return 16'd1;
      1: return 16'd16;
      2: return 16'd5;
      3: return 16'd31;
      4: return 16'd9;
      5: return 16'd2;
      6: return 16'd24;
      7: return 16'd12;
      8: return 16'd32;
      9: return 16'd3;
      10: return 16'd20;
      default: return 16'd7;
    endcase
  endfunction

  // Block until no point is pending, in flight or awaiting its result
  task automatic wait_idle();
    while (points_q.size() != 0 || pt.valid || escapes_due.size() != 0) @(negedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_C_REAL:   cfg_c_real = value;
      REG_C_IMAG:   cfg_c_imag = value;
      REG_MAX_ITER: cfg_limit  = value[15:0];
      default: ;
    endcase
  endtask

  task automatic set_julia(input logic signed [IN_W-1:0] cr, input logic signed [IN_W-1:0] ci,
                           input logic [15:0] lim);
    wait_idle();
    write_reg(REG_C_REAL, cr);
    write_reg(REG_C_IMAG, ci);
    write_reg(REG_MAX_ITER, 32'(lim));
    n_settings++;
  endtask

  // Point driver: one beat per queued point, random gap between beats unless quiet
  always @(posedge clk_i) begin : point_driver
    escape_t e;
    point_t  p;
    if (!rst_ni) begin
      pt.valid <= 1'b0;
    end else begin
      if (pt.valid && pt.ready) begin
        e = julia_escape(pt.z_real, pt.z_imag);
        escapes_due.push_back(e);
        points_sent++;
        if (e.bounded) n_bounded++;
      end
      if (pt.valid && !pt.ready) begin
        // beat still offered
      end else if (tx_gap != 0) begin
        tx_gap--;
        pt.valid <= 1'b0;
      end else if (points_q.size() != 0) begin
        p = points_q.pop_front();
        pt.z_real <= p.re;
        pt.z_imag <= p.im;
        pt.valid  <= 1'b1;
        tx_gap = quiet ? 0 : $urandom_range(0, 3);
      end else begin
        pt.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each beat with the oldest prediction, random back-pressure unless quiet
  always @(posedge clk_i) begin : result_monitor
    escape_t e;
    logic    take;
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (escapes_due.size() == 0) begin
          $error("result beat with no point outstanding");
          errors++;
        end else begin
          e = escapes_due.pop_front();
          if (res.iteration_count !== e.count) begin
            $error("iteration_count: expected %0d, got %0d", e.count, res.iteration_count);
            errors++;
          end
          if (res.bounded !== e.bounded) begin
            $error("bounded: expected %0d, got %0d", e.bounded, res.bounded);
            errors++;
          end
          if (res.smooth_fraction !== e.frac) begin
            $error("smooth_fraction: expected %0d, got %0d", e.frac, res.smooth_fraction);
            errors++;
          end
        end
        results_seen++;
        rx_wait = quiet ? 0 : $urandom_range(0, 3);
        if (results_seen == HOLD_AT) rx_wait = HOLD_LEN;
      end
      if (rx_wait != 0) begin
        rx_wait--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      res.ready <= take;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, escapes_due.size());
      $display("julia_escape_time regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int       p;
    point_t   q;
    logic signed [IN_W-1:0] cr, ci;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    pt.valid   = 1'b0;
    pt.z_real  = '0;
    pt.z_imag  = '0;
    res.ready  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings (c = 0, limit 256): fixed points, slow escape, field extremes
    add_point('0, '0);
    add_point(Q_ONE, '0);
    add_point(-Q_ONE, '0);
    add_point('0, Q_ONE);
    add_point(Q_HALF, Q_HALF);
    add_point(32'sh1000_0001, '0);
    add_point(-Q_TWO, '0);
    add_point(Q_MAX, Q_MAX);
    add_point(Q_MIN, Q_MIN);
    add_point(Q_MIN, '0);
    add_point('0, Q_MAX);

    // Extreme c with the shortest limit
    set_julia(Q_MAX, Q_MIN, 16'd1);
    add_point('0, '0);
    add_point(Q_MAX, Q_MAX);
    add_point(Q_ONE, '0);
    add_point(-Q_TWO, Q_MIN);

    // Largest limit, only with points that leave fast
    set_julia(Q_MIN, '0, 16'hFFFF);
    add_point('0, '0);
    add_point(Q_MIN, Q_MIN);
    add_point(Q_MAX, '0);
    add_point('0, Q_MAX);
    add_point(Q_ONE, Q_ONE);

    // Random phases with short limits
    for (p = 0; p < 12; p++) begin
      cr = near_coord();
      ci = near_coord();
      if (p == 4) begin
        cr = $signed($urandom());
        ci = $signed($urandom());
      end else if (p == 7) begin
        cr = '0;
        ci = '0;
      end
      set_julia(cr, ci, phase_limit(p));
      quiet = (p % 4 == 2);
      repeat (110) begin
        q = rand_point(mix_kind());
        add_point(q.re, q.im);
      end
    end

    // Default limit again, mixed points
    quiet = 1'b0;
    set_julia(near_coord(), near_coord(), MAX_ITER_RESET);
    repeat (30) begin
      q = rand_point(mix_kind());
      add_point(q.re, q.im);
    end

    // Largest limit with random small c and far points
    set_julia(near_coord(), near_coord(), 16'hFFFF);
    repeat (20) begin
      q = rand_point(PT_FAR);
      add_point(q.re, q.im);
    end

    wait_idle();
    repeat (END_WAIT) @(posedge clk_i);
    $display("Covered %0d points (%0d bounded) over %0d c/limit settings, limits 1..65535.",
             points_sent, n_bounded, n_settings);
    $display("Checked %0d result beats, %0d field mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("julia_escape_time regression: pass");
    end else begin
      $display("julia_escape_time regression: fail");
    end
    $finish;
  end

endmodule
